### src/llqm_pkg.sv
// ----------------------------------------------------------------------------
// llqm_pkg
// Shared codes and types for the linked list queue manager.
// ----------------------------------------------------------------------------
package llqm_pkg;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POOL_FULL  = 2'd1,
        ST_NOT_IN_USE = 2'd2
    } status_t;

    // widths of the fixed stream fields
    localparam int ITEM_DATA_W = 32;
    localparam int HANDLE_W    = 4;

endpackage

### src/llqm_ram.sv
// ----------------------------------------------------------------------------
// llqm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module llqm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### src/llqm_free_find.sv
// ----------------------------------------------------------------------------
// llqm_free_find
// Picks the lowest-numbered free entry of the in-use bitmap.
// ----------------------------------------------------------------------------
module llqm_free_find #(
    parameter int POOL_ENTRIES = 16
) (
    input  logic [POOL_ENTRIES-1:0]         in_use,
    output logic                            found,
    output logic [$clog2(POOL_ENTRIES)-1:0] slot
);

    always_comb begin
        found = 1'b0;
        slot  = '0;
        // scan downward so the lowest free index wins
        for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
            if (!in_use[i]) begin
                found = 1'b1;
                slot  = ($clog2(POOL_ENTRIES))'(i);
            end
        end
    end

endmodule

### src/linked_list_queue_manager_core.sv
// ----------------------------------------------------------------------------
// linked_list_queue_manager_core
// Doubly linked list over a fixed pool of entries with head and tail links.
//
// Input channel s_*: one word per command. s_tuser is the operation (add at
// tail or remove by handle), s_tdata carries the data word and the handle.
// Result channel m_*: exactly one word per command with the handle given on
// an add, a status code and a flag telling whether the list is now empty.
// A command is captured in an input register and then executed, which loads
// the result register: m_tvalid rises once the command has passed both
// registers, and one command is taken every cycle while the receiver keeps up.
// The rate is set by the link update between those registers.
// When the receiver stalls, the result register holds, the command in the
// input register waits, and s_tready drops once both are occupied.
// Reset clears the in-use bitmap and sets head and tail to the null code;
// data and link storage are not cleared, since only entries in use are read.
// Commands may be issued right after reset.
// ----------------------------------------------------------------------------
module linked_list_queue_manager_core
    import llqm_pkg::*;
#(
    parameter int POOL_ENTRIES = 16,
    parameter int DATA_WIDTH   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item_data[31:0], entry_handle[35:32], zero pad
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // given_handle[3:0], list_empty[4], zero pad
    output logic [1:0]  m_tuser    // status
);

    localparam int HW = $clog2(POOL_ENTRIES);
    localparam int LW = $clog2(POOL_ENTRIES + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);

    // input register
    logic                   in_valid_reg;
    op_t                    in_op_reg;
    logic [ITEM_DATA_W-1:0] in_data_reg;
    logic [HANDLE_W-1:0]    in_handle_reg;

    // result register
    logic                   out_valid_reg;
    logic [HANDLE_W-1:0]    out_given_reg;
    status_t                out_status_reg;
    logic                   out_empty_reg;

    // list state
    logic [POOL_ENTRIES-1:0] in_use_reg;
    logic [LW-1:0]           prev_link_reg [POOL_ENTRIES];
    logic [LW-1:0]           next_link_reg [POOL_ENTRIES];
    logic [LW-1:0]           head_reg, head_next;
    logic [LW-1:0]           tail_reg, tail_next;

    logic            advance;
    logic            free_found;
    logic [HW-1:0]   free_slot;
    logic [31:0]     handle_wide;
    logic            handle_in_pool;
    logic [HW-1:0]   rm_idx;
    logic [LW-1:0]   before_link, after_link;
    logic            before_null, after_null;
    logic [LW-1:0]   before_norm, after_norm;
    logic            head_null, tail_null;
    logic            add_ok, rm_ok;
    status_t         status_next;
    logic [DATA_WIDTH-1:0] unused_rd_data;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg     <= op_t'(s_tuser);
            in_data_reg   <= s_tdata[ITEM_DATA_W-1:0];
            in_handle_reg <= s_tdata[ITEM_DATA_W +: HANDLE_W];
        end
    end

    llqm_free_find #(
        .POOL_ENTRIES(POOL_ENTRIES)
    ) u_free_find (
        .in_use (in_use_reg),
        .found  (free_found),
        .slot   (free_slot)
    );

    always_comb begin
        handle_wide    = 32'(in_handle_reg);
        handle_in_pool = handle_wide < 32'(POOL_ENTRIES);
        rm_idx         = handle_wide[HW-1:0];
        before_link    = prev_link_reg[rm_idx];
        after_link     = next_link_reg[rm_idx];
        before_null    = before_link >= NULL_LINK;
        after_null     = after_link >= NULL_LINK;
        before_norm    = before_null ? NULL_LINK : before_link;
        after_norm     = after_null ? NULL_LINK : after_link;
        head_null      = head_reg >= NULL_LINK;
        tail_null      = tail_reg >= NULL_LINK;
        add_ok         = 1'b0;
        rm_ok          = 1'b0;
        status_next    = ST_OK;
        case (in_op_reg)
            OP_ADD: begin
                add_ok = advance && free_found;
                if (!free_found) begin
                    status_next = ST_POOL_FULL;
                end
            end
            OP_REMOVE: begin
                rm_ok = advance && handle_in_pool && in_use_reg[rm_idx];
                if (!(handle_in_pool && in_use_reg[rm_idx])) begin
                    status_next = ST_NOT_IN_USE;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (add_ok) begin
            if (head_null || tail_null) begin
                head_next = LW'(free_slot);
            end
            tail_next = LW'(free_slot);
        end else if (rm_ok) begin
            if (before_null) begin
                head_next = after_norm;
            end
            if (after_null) begin
                tail_next = before_norm;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= NULL_LINK;
            tail_reg   <= NULL_LINK;
            in_use_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            if (add_ok) begin
                in_use_reg[free_slot] <= 1'b1;
            end else if (rm_ok) begin
                in_use_reg[rm_idx] <= 1'b0;
            end
        end
    end

    // link storage, only read for entries in use
    always_ff @(posedge aclk) begin
        if (add_ok) begin
            next_link_reg[free_slot] <= NULL_LINK;
            if (head_null || tail_null) begin
                prev_link_reg[free_slot] <= NULL_LINK;
            end else begin
                prev_link_reg[free_slot]      <= tail_reg;
                next_link_reg[tail_reg[HW-1:0]] <= LW'(free_slot);
            end
        end else if (rm_ok) begin
            if (!before_null) begin
                next_link_reg[before_link[HW-1:0]] <= after_norm;
            end
            if (!after_null) begin
                prev_link_reg[after_link[HW-1:0]] <= before_norm;
            end
        end
    end

    llqm_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(POOL_ENTRIES)
    ) u_data_store (
        .aclk    (aclk),
        .wr_en   (add_ok),
        .wr_addr (free_slot),
        .wr_data (DATA_WIDTH'(in_data_reg)),
        .rd_addr (rm_idx),
        .rd_data (unused_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_given_reg  <= add_ok ? HANDLE_W'(free_slot) : '0;
            out_status_reg <= status_next;
            out_empty_reg  <= head_next >= NULL_LINK;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_empty_reg, out_given_reg};
    assign m_tuser  = out_status_reg;

    // head and tail are null together
    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == NULL_LINK) == (tail_reg == NULL_LINK))
        else $error("head and tail null codes disagree");

    // an empty list means no entry is in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == NULL_LINK) == (in_use_reg == '0))
        else $error("list empty flag disagrees with in-use bitmap");

    // a successful add leaves the new entry at the tail, in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        add_ok |=> (tail_reg != NULL_LINK) && in_use_reg[tail_reg[HW-1:0]])
        else $error("added entry not linked at tail");

    // pool full is only reported when every entry is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == OP_ADD && !free_found) |-> (&in_use_reg))
        else $error("pool full reported with a free entry");

endmodule
